[design/ftc_pkg.sv]
// Shared types, codes and helpers of the five-tuple ternary classifier.
// No dependencies.
package ftc_pkg;

  typedef enum logic [1:0] {
    CMD_LOOKUP  = 2'd0,
    CMD_WR_HDR  = 2'd1,
    CMD_WR_PORT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic load;
    logic scan;
  } ftc_ctl_t;

  typedef struct packed {
    logic done;
  } ftc_sts_t;

  localparam int unsigned HdrW = 100;
  localparam int unsigned PortW = 32;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    prefix_mask = ~(32'hffffffff >> len);
  endfunction

endpackage

[design/five_tuple_ternary_classifier.sv]
// Top level of the five-tuple ternary classifier with its APB register.
// Depends on ftc_pkg, ftc_ctrl and ftc_datapath.
//
// Usage: a request is taken when start_i is high and busy_o is low.
// Header and port slot writes complete in the cycle they are taken and
// give no result, so they can follow one another in every cycle. A lookup
// scans the rules from index zero, one rule per cycle through the rule
// memories, and stops at the first match. Its one result shows on hit_o,
// match_class_o and match_index_o while result_valid_o is high for a single
// cycle. The result cycle follows the registered rule read, hit_q (on a hit)
// and the move to ST_RESULT; on a miss, the read of the last searched rule and
// that move. busy_o stays high until the result cycle has passed, so the next
// request is taken in the cycle after it at the earliest. The active_rules
// register sits at APB address 0; the user must write it only while the block
// is idle, which the block does not enforce. Reset clears the controller and
// the register to zero; the rule tables hold no defined contents until
// written. The receiver cannot stall; each result must be taken in its cycle.
module five_tuple_ternary_classifier import ftc_pkg::*; #(
  parameter int unsigned NUM_RULES       = 256,
  parameter int unsigned DEST_PORT_SLOTS = 4,
  parameter int unsigned SRC_PORT_SLOTS  = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  rule_index_i,
  input  logic [31:0] dest_ip_i,
  input  logic [31:0] src_ip_i,
  input  logic [5:0]  dest_prefix_len_i,
  input  logic [5:0]  src_prefix_len_i,
  input  logic [15:0] dest_port_i,
  input  logic [15:0] src_port_i,
  input  logic [7:0]  proto_i,
  input  logic [15:0] rule_class_i,
  input  logic [3:0]  port_slot_i,
  input  logic [15:0] port_mask_i,
  output logic        result_valid_o,
  output logic        hit_o,
  output logic [15:0] match_class_o,
  output logic [7:0]  match_index_o
);
  logic [8:0] active_rules_q;
  ftc_ctl_t   ctl;
  ftc_sts_t   sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_rules_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      active_rules_q <= pwdata[8:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {23'd0, active_rules_q};

  ftc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .command_i      (command_i),
    .sts_i          (sts),
    .ctl_o          (ctl),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  ftc_datapath #(
    .NUM_RULES       (NUM_RULES),
    .DEST_PORT_SLOTS (DEST_PORT_SLOTS),
    .SRC_PORT_SLOTS  (SRC_PORT_SLOTS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .active_rules_i    (active_rules_q),
    .command_i         (command_i),
    .rule_index_i      (rule_index_i),
    .dest_ip_i         (dest_ip_i),
    .src_ip_i          (src_ip_i),
    .dest_prefix_len_i (dest_prefix_len_i),
    .src_prefix_len_i  (src_prefix_len_i),
    .dest_port_i       (dest_port_i),
    .src_port_i        (src_port_i),
    .proto_i           (proto_i),
    .rule_class_i      (rule_class_i),
    .port_slot_i       (port_slot_i),
    .port_mask_i       (port_mask_i),
    .hit_o             (hit_o),
    .match_class_o     (match_class_o),
    .match_index_o     (match_index_o)
  );
endmodule

[design/ftc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ftc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[design/ftc_ctrl.sv]
// Controller of the classifier: accepts requests and sequences lookups.
// Depends on ftc_pkg.
module ftc_ctrl import ftc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic [1:0] command_i,
  input  ftc_sts_t sts_i,
  output ftc_ctl_t ctl_o,
  output logic     busy_o,
  output logic     result_valid_o
);
  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_RESULT} state_e;
  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i && cmd_e'(command_i) == CMD_LOOKUP) state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (sts_i.done) state_q <= ST_RESULT;
        end
        ST_RESULT: state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o         = state_q != ST_IDLE;
  assign result_valid_o = state_q == ST_RESULT;
  assign ctl_o.load     = state_q == ST_IDLE && start_i;
  assign ctl_o.scan     = state_q == ST_SCAN;
endmodule

[design/ftc_datapath.sv]
// Datapath of the classifier: rule memories, scan counter and match logic.
// Depends on ftc_pkg and ftc_ram.
module ftc_datapath import ftc_pkg::*; #(
  parameter int unsigned NUM_RULES       = 256,
  parameter int unsigned DEST_PORT_SLOTS = 4,
  parameter int unsigned SRC_PORT_SLOTS  = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ftc_ctl_t    ctl_i,
  output ftc_sts_t    sts_o,
  input  logic [8:0]  active_rules_i,
  input  logic [1:0]  command_i,
  input  logic [7:0]  rule_index_i,
  input  logic [31:0] dest_ip_i,
  input  logic [31:0] src_ip_i,
  input  logic [5:0]  dest_prefix_len_i,
  input  logic [5:0]  src_prefix_len_i,
  input  logic [15:0] dest_port_i,
  input  logic [15:0] src_port_i,
  input  logic [7:0]  proto_i,
  input  logic [15:0] rule_class_i,
  input  logic [3:0]  port_slot_i,
  input  logic [15:0] port_mask_i,
  output logic        hit_o,
  output logic [15:0] match_class_o,
  output logic [7:0]  match_index_o
);
  localparam int unsigned Slots = DEST_PORT_SLOTS + SRC_PORT_SLOTS;
  localparam int unsigned AW = NUM_RULES > 1 ? $clog2(NUM_RULES) : 1;
  localparam int unsigned CW = $clog2(NUM_RULES + 1) > AW ? $clog2(NUM_RULES + 1) : AW;
  localparam int unsigned IW = AW > 8 ? AW : 8;

  logic [31:0]   pk_dip_q, pk_sip_q;
  logic [15:0]   pk_dport_q, pk_sport_q;
  logic [7:0]    pk_proto_q;
  logic [CW-1:0] cnt_q, lim_q;
  logic [AW-1:0] rd_idx_q;
  logic          rd_valid_q;
  logic          hit_q;
  logic [15:0]   class_q;
  logic [AW-1:0] idx_q;

  logic [IW-1:0] wr_idx;
  logic          idx_ok, wr_hdr, wr_port;
  logic [31:0]   lim32;
  logic          issue;
  logic [HdrW-1:0] hdr_rd;
  logic [Slots-1:0] slot_hit;
  logic          dok, sok, match;
  logic [IW-1:0] idx_ext;

  assign wr_idx  = IW'(rule_index_i);
  assign idx_ok  = {24'd0, rule_index_i} < 32'(NUM_RULES);
  assign wr_hdr  = ctl_i.load && cmd_e'(command_i) == CMD_WR_HDR && idx_ok;
  assign wr_port = ctl_i.load && cmd_e'(command_i) == CMD_WR_PORT && idx_ok;
  assign lim32   = {23'd0, active_rules_i} > 32'(NUM_RULES) ? 32'(NUM_RULES)
                                                           : {23'd0, active_rules_i};
  assign issue   = ctl_i.scan && cnt_q < lim_q && !hit_q;

  ftc_ram #(.WIDTH(HdrW), .DEPTH(NUM_RULES)) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (wr_hdr),
    .waddr_i (wr_idx[AW-1:0]),
    .wdata_i ({dest_ip_i, src_ip_i, dest_prefix_len_i, src_prefix_len_i,
               proto_i, rule_class_i}),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (hdr_rd)
  );

  for (genvar k = 0; k < Slots; k++) begin : g_slot
    logic [PortW-1:0] prd;
    logic [15:0]      port;
    ftc_ram #(.WIDTH(PortW), .DEPTH(NUM_RULES)) u_port_ram (
      .clk_i   (clk_i),
      .we_i    (wr_port && port_slot_i == 4'(k)),
      .waddr_i (wr_idx[AW-1:0]),
      .wdata_i ({dest_port_i, port_mask_i}),
      .raddr_i (cnt_q[AW-1:0]),
      .rdata_o (prd)
    );
    assign port        = k < DEST_PORT_SLOTS ? pk_dport_q : pk_sport_q;
    assign slot_hit[k] = ((port ^ prd[31:16]) & prd[15:0]) == 16'd0;
  end

  assign dok = |slot_hit[DEST_PORT_SLOTS-1:0];
  assign sok = |slot_hit[Slots-1:DEST_PORT_SLOTS];
  assign match = dok && sok
      && ((pk_dip_q ^ hdr_rd[99:68]) & prefix_mask(hdr_rd[35:30])) == 32'd0
      && ((pk_sip_q ^ hdr_rd[67:36]) & prefix_mask(hdr_rd[29:24])) == 32'd0
      && pk_proto_q == hdr_rd[23:16];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      pk_dip_q   <= dest_ip_i;
      pk_sip_q   <= src_ip_i;
      pk_dport_q <= dest_port_i;
      pk_sport_q <= src_port_i;
      pk_proto_q <= proto_i;
      lim_q      <= CW'(lim32);
    end
    if (issue) begin
      rd_idx_q <= cnt_q[AW-1:0];
    end
    if (rd_valid_q && !hit_q && match) begin
      class_q <= hdr_rd[15:0];
      idx_q   <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      rd_valid_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      rd_valid_q <= issue;
      if (ctl_i.load) begin
        cnt_q <= '0;
        hit_q <= 1'b0;
      end else begin
        if (issue) cnt_q <= cnt_q + CW'(1);
        if (rd_valid_q && match) hit_q <= 1'b1;
      end
    end
  end

  assign sts_o.done    = hit_q || (cnt_q == lim_q && !rd_valid_q);
  assign idx_ext       = IW'(idx_q);
  assign hit_o         = hit_q;
  assign match_class_o = hit_q ? class_q : 16'd0;
  assign match_index_o = hit_q ? idx_ext[7:0] : 8'd0;
endmodule

[dv/five_tuple_ternary_classifier_tb.sv]
// Self-checking testbench for five_tuple_ternary_classifier: rule table writes,
// lookups and the active_rules register, checked against an in-bench rule table.
// Depends on ftc_pkg and the design files only.
module five_tuple_ternary_classifier_tb import ftc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RULES = 64;
  localparam int unsigned DSLOTS = 4;
  localparam int unsigned SLOTS = 9;
  localparam logic [2:0] ACTIVE_RULES_ADDR = 3'd0;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct {
    cmd_e        cmd;
    logic [7:0]  idx;
    logic [31:0] dip;
    logic [31:0] sip;
    logic [5:0]  dlen;
    logic [5:0]  slen;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [7:0]  proto;
    logic [15:0] cls;
    logic [3:0]  slot;
    logic [15:0] pmask;
  } req_t;

  typedef struct {
    logic        hit;
    logic [15:0] cls;
    logic [7:0]  idx;
  } match_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] command_i = '0;
  logic [7:0] rule_index_i = '0;
  logic [31:0] dest_ip_i = '0, src_ip_i = '0;
  logic [5:0] dest_prefix_len_i = '0, src_prefix_len_i = '0;
  logic [15:0] dest_port_i = '0, src_port_i = '0, rule_class_i = '0, port_mask_i = '0;
  logic [7:0] proto_i = '0;
  logic [3:0] port_slot_i = '0;
  logic result_valid_o, hit_o;
  logic [15:0] match_class_o;
  logic [7:0] match_index_o;

  five_tuple_ternary_classifier #(.NUM_RULES(RULES)) uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [31:0] dip_tab [RULES];
  logic [31:0] sip_tab [RULES];
  logic [5:0]  dlen_tab [RULES];
  logic [5:0]  slen_tab [RULES];
  logic [7:0]  proto_tab [RULES];
  logic [15:0] cls_tab [RULES];
  logic [15:0] pdata_tab [RULES][SLOTS];
  logic [15:0] pmask_tab [RULES][SLOTS];
  int unsigned active_cnt = 0;
  match_t match_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;

  function automatic logic [31:0] len_mask(logic [5:0] len);
    if (len == 6'd0) return 32'h0;
    if (len >= 6'd32) return 32'hffffffff;
    return ~(32'hffffffff >> len);
  endfunction

  function automatic logic rule_hits(int unsigned r, req_t q);
    logic dok = 1'b0, sok = 1'b0;
    if (((q.dip ^ dip_tab[r]) & len_mask(dlen_tab[r])) != 0) return 1'b0;
    if (((q.sip ^ sip_tab[r]) & len_mask(slen_tab[r])) != 0) return 1'b0;
    if (q.proto != proto_tab[r]) return 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      if (((k < DSLOTS ? q.dport : q.sport) ^ pdata_tab[r][k]) & pmask_tab[r][k]) continue;
      if (k < DSLOTS) dok = 1'b1;
      else sok = 1'b1;
    end
    return dok && sok;
  endfunction

  function automatic void apply_request(req_t q);
    match_t m = '{1'b0, 16'h0, 8'h0};
    int unsigned lim = active_cnt > RULES ? RULES : active_cnt;
    case (q.cmd)
      CMD_LOOKUP: begin
        for (int unsigned r = 0; r < lim; r++) begin
          if (rule_hits(r, q)) begin
            m = '{1'b1, cls_tab[r], r[7:0]};
            break;
          end
        end
        match_q = {match_q, m};
      end
      CMD_WR_HDR: begin
        if (q.idx < RULES) begin
          dip_tab[q.idx] = q.dip;
          sip_tab[q.idx] = q.sip;
          dlen_tab[q.idx] = q.dlen;
          slen_tab[q.idx] = q.slen;
          proto_tab[q.idx] = q.proto;
          cls_tab[q.idx] = q.cls;
        end
      end
      CMD_WR_PORT: begin
        if (q.idx < RULES && q.slot < SLOTS) begin
          pdata_tab[q.idx][q.slot] = q.dport;
          pmask_tab[q.idx][q.slot] = q.pmask;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input req_t q);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    command_i <= q.cmd;
    rule_index_i <= q.idx;
    dest_ip_i <= q.dip;
    src_ip_i <= q.sip;
    dest_prefix_len_i <= q.dlen;
    src_prefix_len_i <= q.slen;
    dest_port_i <= q.dport;
    src_port_i <= q.sport;
    proto_i <= q.proto;
    rule_class_i <= q.cls;
    port_slot_i <= q.slot;
    port_mask_i <= q.pmask;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    apply_request(q);
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (match_q.size() != 0 || busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_active_rules(input logic [31:0] value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ACTIVE_RULES_ADDR;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    active_cnt = int'(value[8:0]);
    @(posedge clk_i);
  endtask

  function automatic req_t blank_request(cmd_e cmd);
    req_t q;
    q.cmd = cmd;
    q.idx = 8'($urandom);
    q.dip = $urandom;
    q.sip = $urandom;
    q.dlen = 6'($urandom);
    q.slen = 6'($urandom);
    q.dport = 16'($urandom);
    q.sport = 16'($urandom);
    q.proto = 8'($urandom);
    q.cls = 16'($urandom);
    q.slot = 4'($urandom);
    q.pmask = 16'($urandom);
    return q;
  endfunction

  function automatic req_t header_write(logic [7:0] idx);
    req_t q = blank_request(CMD_WR_HDR);
    q.idx = idx;
    q.dlen = $urandom_range(0, 7) == 0 ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 24));
    q.slen = $urandom_range(0, 7) == 0 ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 24));
    q.proto = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
    return q;
  endfunction

  function automatic req_t port_write(logic [7:0] idx, logic [3:0] slot);
    req_t q = blank_request(CMD_WR_PORT);
    q.idx = idx;
    q.slot = slot;
    case ($urandom_range(0, 3))
      0: q.pmask = 16'h0;
      1: q.pmask = 16'hffff;
      default: q.pmask = 16'($urandom);
    endcase
    return q;
  endfunction

  // Builds a packet aimed at one stored rule; now and then one field is broken.
  function automatic req_t aimed_lookup();
    req_t q = blank_request(CMD_LOOKUP);
    int unsigned hi = active_cnt == 0 ? RULES - 1 : (active_cnt > RULES ? RULES : active_cnt) - 1;
    int unsigned r = $urandom_range(0, hi);
    int unsigned kd = $urandom_range(0, DSLOTS - 1);
    int unsigned ks = $urandom_range(DSLOTS, SLOTS - 1);
    logic [31:0] m;
    m = len_mask(dlen_tab[r]);
    q.dip = (dip_tab[r] & m) | (q.dip & ~m);
    m = len_mask(slen_tab[r]);
    q.sip = (sip_tab[r] & m) | (q.sip & ~m);
    q.dport = (pdata_tab[r][kd] & pmask_tab[r][kd]) | (q.dport & ~pmask_tab[r][kd]);
    q.sport = (pdata_tab[r][ks] & pmask_tab[r][ks]) | (q.sport & ~pmask_tab[r][ks]);
    q.proto = proto_tab[r];
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 4))
        0: q.dip[$urandom_range(0, 31)] ^= 1'b1;
        1: q.sip[$urandom_range(0, 31)] ^= 1'b1;
        2: q.dport[$urandom_range(0, 15)] ^= 1'b1;
        3: q.sport[$urandom_range(0, 15)] ^= 1'b1;
        default: q.proto[$urandom_range(0, 7)] ^= 1'b1;
      endcase
    end
    return q;
  endfunction

  function automatic req_t random_request();
    int unsigned pick = $urandom_range(0, 99);
    if (pick < 60) return aimed_lookup();
    if (pick < 68) return blank_request(CMD_LOOKUP);
    if (pick < 82) return header_write(8'($urandom_range(0, RULES + 15)));
    if (pick < 97) return port_write(8'($urandom_range(0, RULES + 15)),
                                     $urandom_range(0, 9) == 0 ? 4'($urandom) :
                                     4'($urandom_range(0, SLOTS - 1)));
    return blank_request(CMD_NONE);
  endfunction

  task automatic test_table_load();
    for (int r = 0; r < RULES; r++) begin
      send_request(header_write(8'(r)));
      for (int k = 0; k < SLOTS; k++) send_request(port_write(8'(r), 4'(k)));
    end
  endtask

  task automatic test_directed();
    req_t q;
    write_active_rules(32'(RULES));
    q = blank_request(CMD_LOOKUP);
    q.dip = '1; q.sip = '1; q.dport = '1; q.sport = '1; q.proto = '1;
    send_request(q);
    q.dip = '0; q.sip = '0; q.dport = '0; q.sport = '0; q.proto = '0;
    send_request(q);
    q = header_write(8'(RULES - 1));
    q.dlen = 6'd0; q.slen = 6'd63; q.cls = '1; q.proto = '1;
    send_request(q);
    q = header_write(8'd0);
    q.dlen = 6'd32; q.slen = 6'd40; q.cls = '0;
    send_request(q);
    q = header_write(8'd255);
    send_request(q);
    q = port_write(8'd255, 4'd15);
    send_request(q);
    q = port_write(8'(RULES - 1), 4'(SLOTS - 1));
    q.pmask = '1; q.dport = '1;
    send_request(q);
    q = port_write(8'd0, 4'd0);
    q.pmask = '0;
    send_request(q);
    send_request(blank_request(CMD_NONE));
    for (int i = 0; i < 8; i++) send_request(aimed_lookup());
    write_active_rules(32'd0);
    send_request(aimed_lookup());
    write_active_rules(32'hffff_ffff);
    send_request(aimed_lookup());
    write_active_rules(32'd1);
    send_request(aimed_lookup());
    send_request(blank_request(CMD_LOOKUP));
  endtask

  task automatic test_random_phases();
    logic [31:0] setting;
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: setting = 32'(RULES);
        1: setting = $urandom_range(1, 16);
        2: setting = $urandom;
        default: setting = $urandom_range(0, 511);
      endcase
      write_active_rules(setting);
      repeat (170) send_request(random_request());
    end
  endtask

  always @(posedge clk_i) begin
    match_t m;
    if (result_valid_o) begin
      if (match_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b class=%h index=%0d",
                 $time, hit_o, match_class_o, match_index_o);
        errors++;
      end else begin
        m = match_q.pop_front();
        if (hit_o !== m.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, m.hit, hit_o);
          errors++;
        end
        if (match_class_o !== m.cls) begin
          $display("%0t: class expected %h actual %h", $time, m.cls, match_class_o);
          errors++;
        end
        if (match_index_o !== m.idx) begin
          $display("%0t: index expected %0d actual %0d", $time, m.idx, match_index_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_load();
    test_directed();
    test_random_phases();
    wait_idle();
    repeat (300) @(posedge clk_i);
    if (errors == 0 && match_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/ftc_pkg.sv
design/ftc_ram.sv
design/ftc_ctrl.sv
design/ftc_datapath.sv
design/five_tuple_ternary_classifier.sv
dv/five_tuple_ternary_classifier_tb.sv
